// ===== design/gated_short_causal_conv3_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for gated_short_causal_conv3
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef GATED_SHORT_CAUSAL_CONV3_MACROS_SVH
`define GATED_SHORT_CAUSAL_CONV3_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSCC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gscc_pkg.sv =====
// ----------------------------------------------------------------------------
// gscc_pkg
// Sizes, field offsets, shared types and the Q3.12 round-and-saturate
// function of the gated short causal convolution.
// ----------------------------------------------------------------------------
package gscc_pkg;

    localparam int LAYERS     = 16;
    localparam int CHANNELS   = 2048;
    localparam int HIST_DEPTH = LAYERS * CHANNELS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam int LAYER_W   = 4;
    localparam int CHAN_W    = 11;
    localparam int Q_W       = 16;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = 2 * Q_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int ENTRY_W   = 2 * Q_W;

    localparam int OFS_LAYER = 0;
    localparam int OFS_CHAN  = OFS_LAYER + LAYER_W;
    localparam int OFS_B     = OFS_CHAN + CHAN_W;
    localparam int OFS_C     = OFS_B + Q_W;
    localparam int OFS_X     = OFS_C + Q_W;
    localparam int OFS_W0    = OFS_X + Q_W;
    localparam int OFS_W1    = OFS_W0 + Q_W;
    localparam int OFS_W2    = OFS_W1 + Q_W;
    localparam int IN_BITS   = OFS_W2 + Q_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = Q_W;

    localparam int Q_MAX = (1 << (Q_W - 1)) - 1;
    localparam int Q_MIN = -(1 << (Q_W - 1));

    typedef logic signed [Q_W-1:0]    q_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [HIST_AW-1:0]       hist_addr_t;
    typedef logic [ENTRY_W-1:0]       hist_entry_t;

    typedef struct packed {
        logic clip;
        q_t   value;
    } rsat_t;

    // One item leaving the history stage.
    typedef struct packed {
        q_t   g;
        q_t   h_old;
        q_t   h_new;
        q_t   w0;
        q_t   w1;
        q_t   w2;
        q_t   c;
        logic clip;
    } gate_item_t;

    function automatic acc_t widen(prod_t p);
        return {{(ACC_W - PROD_W){p[PROD_W-1]}}, p};
    endfunction

    // Q6.24 to Q3.12: add half an LSB, floor by arithmetic shift, then clip.
    function automatic rsat_t round_sat(acc_t v);
        acc_t  r;
        rsat_t res;
        r = (v + acc_t'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > acc_t'(Q_MAX))
        begin
            res.clip  = 1'b1;
            res.value = q_t'(Q_MAX);
        end
        else if (r < acc_t'(Q_MIN))
        begin
            res.clip  = 1'b1;
            res.value = q_t'(Q_MIN);
        end
        else
        begin
            res.clip  = 1'b0;
            res.value = r[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== design/gscc_hist_ram.sv =====
// ----------------------------------------------------------------------------
// gscc_hist_ram
// History memory: one write port and one read port, read data registered.
// A read and a write to the same entry in one cycle return the old data.
// ----------------------------------------------------------------------------
module gscc_hist_ram
    import gscc_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  hist_addr_t  waddr,
    input  hist_entry_t wdata,
    input  logic        re,
    input  hist_addr_t  raddr,
    output hist_entry_t rdata
);

    hist_entry_t mem [HIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/gscc_gate_stage.sv =====
// ----------------------------------------------------------------------------
// gscc_gate_stage
// Input stage: takes items, reads the layer-channel history, forms the gated
// sample and writes the shifted history back. Clears the memory after reset.
// ----------------------------------------------------------------------------
module gscc_gate_stage
    import gscc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  item_valid,
    input  logic                  item_ready,
    output gate_item_t            item
);

    logic         clr_active_reg, clr_active_next;
    hist_addr_t   clr_cnt_reg, clr_cnt_next;
    logic         s1_v_reg, s1_v_next;
    logic         s1_ok_reg;
    hist_addr_t   s1_addr_reg;
    prod_t        s1_prod_reg;
    q_t           s1_c_reg, s1_w0_reg, s1_w1_reg, s1_w2_reg;
    logic         byp_hit_reg;
    hist_entry_t  byp_data_reg;

    logic [LAYER_W-1:0] in_layer;
    logic [CHAN_W-1:0]  in_chan;
    q_t                 in_b, in_x;
    logic               in_ok;
    hist_addr_t         in_addr;
    logic               accept, s1_adv, wb_en;
    hist_entry_t        mem_q, entry, wb_data;
    rsat_t              g_rs;
    logic               ram_we;
    hist_addr_t         ram_waddr;
    hist_entry_t        ram_wdata;

    assign in_layer = s_axis_tdata[OFS_LAYER +: LAYER_W];
    assign in_chan  = s_axis_tdata[OFS_CHAN +: CHAN_W];
    assign in_b     = s_axis_tdata[OFS_B +: Q_W];
    assign in_x     = s_axis_tdata[OFS_X +: Q_W];
    assign in_ok    = (32'(in_layer) < LAYERS) && (32'(in_chan) < CHANNELS);
    assign in_addr  = HIST_AW'(32'(in_layer) * 32'(CHANNELS) + 32'(in_chan));

    assign s1_adv        = s1_v_reg && item_ready;
    assign s_axis_tready = !clr_active_reg && (!s1_v_reg || item_ready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The item leaving stage one writes at the same edge as a new read; a
    // read of that same entry picks up the written value from the bypass.
    assign entry   = !s1_ok_reg ? '0 : (byp_hit_reg ? byp_data_reg : mem_q);
    assign g_rs    = round_sat(widen(s1_prod_reg));
    assign wb_data = {g_rs.value, entry[ENTRY_W-1:Q_W]};
    assign wb_en   = s1_adv && s1_ok_reg;

    assign ram_we    = clr_active_reg || wb_en;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : wb_data;

    gscc_hist_ram u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (mem_q)
    );

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == HIST_AW'(HIST_DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
        s1_v_next = accept || (s1_v_reg && !item_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_v_reg       <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            s1_v_reg       <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg    <= in_ok;
            s1_addr_reg  <= in_addr;
            s1_prod_reg  <= prod_t'(in_b) * prod_t'(in_x);
            s1_c_reg     <= s_axis_tdata[OFS_C +: Q_W];
            s1_w0_reg    <= s_axis_tdata[OFS_W0 +: Q_W];
            s1_w1_reg    <= s_axis_tdata[OFS_W1 +: Q_W];
            s1_w2_reg    <= s_axis_tdata[OFS_W2 +: Q_W];
            byp_hit_reg  <= wb_en && in_ok && (s1_addr_reg == in_addr);
            byp_data_reg <= wb_data;
        end
    end

    assign item_valid  = s1_v_reg;
    assign item.g      = g_rs.value;
    assign item.h_old  = entry[Q_W-1:0];
    assign item.h_new  = entry[ENTRY_W-1:Q_W];
    assign item.w0     = s1_w0_reg;
    assign item.w1     = s1_w1_reg;
    assign item.w2     = s1_w2_reg;
    assign item.c      = s1_c_reg;
    assign item.clip   = g_rs.clip;

endmodule

// ===== design/gscc_conv_pipe.sv =====
// ----------------------------------------------------------------------------
// gscc_conv_pipe
// Arithmetic pipeline: three tap products, rounded sum, output gate product
// and final rounding into the output register.
// ----------------------------------------------------------------------------
module gscc_conv_pipe
    import gscc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  gate_item_t             item,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser
);

    logic       s2_v_reg, s2_v_next;
    gate_item_t s2_reg;
    logic       s3_v_reg, s3_v_next;
    prod_t      s3_p0_reg, s3_p1_reg, s3_p2_reg;
    q_t         s3_c_reg;
    logic       s3_clip_reg;
    logic       s4_v_reg, s4_v_next;
    q_t         s4_y_reg, s4_c_reg;
    logic       s4_clip_reg;
    logic       s5_v_reg, s5_v_next;
    prod_t      s5_prod_reg;
    logic       s5_clip_reg;
    logic       out_v_reg, out_v_next;
    q_t         out_data_reg;
    logic       out_sat_reg;

    logic  rdy_out, rdy5, rdy4, rdy3, rdy2;
    acc_t  sum;
    rsat_t y_rs, r_rs;

    assign rdy_out    = !out_v_reg || m_axis_tready;
    assign rdy5       = !s5_v_reg || rdy_out;
    assign rdy4       = !s4_v_reg || rdy5;
    assign rdy3       = !s3_v_reg || rdy4;
    assign rdy2       = !s2_v_reg || rdy3;
    assign item_ready = rdy2;

    assign sum  = widen(s3_p0_reg) + widen(s3_p1_reg) + widen(s3_p2_reg);
    assign y_rs = round_sat(sum);
    assign r_rs = round_sat(widen(s5_prod_reg));

    always_comb
    begin
        s2_v_next  = rdy2 ? item_valid : s2_v_reg;
        s3_v_next  = rdy3 ? s2_v_reg : s3_v_reg;
        s4_v_next  = rdy4 ? s3_v_reg : s4_v_reg;
        s5_v_next  = rdy5 ? s4_v_reg : s5_v_reg;
        out_v_next = rdy_out ? s5_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg  <= s2_v_next;
            s3_v_reg  <= s3_v_next;
            s4_v_reg  <= s4_v_next;
            s5_v_reg  <= s5_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_reg <= item;
        end
        if (rdy3)
        begin
            s3_p0_reg   <= prod_t'(s2_reg.w0) * prod_t'(s2_reg.h_old);
            s3_p1_reg   <= prod_t'(s2_reg.w1) * prod_t'(s2_reg.h_new);
            s3_p2_reg   <= prod_t'(s2_reg.w2) * prod_t'(s2_reg.g);
            s3_c_reg    <= s2_reg.c;
            s3_clip_reg <= s2_reg.clip;
        end
        if (rdy4)
        begin
            s4_y_reg    <= y_rs.value;
            s4_c_reg    <= s3_c_reg;
            s4_clip_reg <= s3_clip_reg || y_rs.clip;
        end
        if (rdy5)
        begin
            s5_prod_reg <= prod_t'(s4_y_reg) * prod_t'(s4_c_reg);
            s5_clip_reg <= s4_clip_reg;
        end
        if (rdy_out)
        begin
            out_data_reg <= r_rs.value;
            out_sat_reg  <= s5_clip_reg || r_rs.clip;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule

// ===== design/gated_short_causal_conv3.sv =====
// ----------------------------------------------------------------------------
// gated_short_causal_conv3
// Gated depthwise causal convolution with three taps, history per layer and
// channel kept in one synchronous memory.
//
//   Channel   Dir   Payload (low bits first)
//   s_axis    in    layer_index, channel_index, gate_in, gate_out, value_in,
//                   tap_oldest, tap_middle, tap_newest
//   m_axis    out   tdata: conv_result; tuser: saturated
//
// One item per cycle sustained while m_axis is not stalled; items pass the
// gate-stage register, s2 to s5 and the output register. The history
// read-modify-write has a bypass for back-to-back items on the same layer
// and channel. After reset the history memory is cleared one entry per
// cycle, 32768 entries, with s_axis_tready low. A stall on m_axis backs up the
// pipeline register by register; input is taken while any register is free.
// ----------------------------------------------------------------------------
module gated_short_causal_conv3
    import gscc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // layer_index, channel_index, gate_in, gate_out, value_in,
    // tap_oldest, tap_middle, tap_newest, one pad bit
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // conv_result
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // saturated
    output logic                   m_axis_tuser
);

    logic       item_valid;
    logic       item_ready;
    gate_item_t item;

    gscc_gate_stage u_gate_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    gscc_conv_pipe u_conv_pipe (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== design/gscc_checker.sv =====
// ----------------------------------------------------------------------------
// gscc_checker
// Port-level checks of the convolution block: output hold under stall and
// the count of items in flight.
// ----------------------------------------------------------------------------
`include "gated_short_causal_conv3_macros.svh"

module gscc_checker
    import gscc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // Pipeline registers that can hold an item, including the output register.
    localparam logic [3:0] MAX_IN_FLIGHT = 4'd6;

    logic [3:0] inflight_reg, inflight_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg + {3'd0, in_acc} - {3'd0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `GSCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `GSCC_ASSERT_IMPL(a_no_phantom, m_axis_tvalid, inflight_reg != 4'd0, "result without an item in flight")

    `GSCC_ASSERT_IMPL(a_bounded, in_acc || m_axis_tvalid || !in_acc, inflight_reg <= MAX_IN_FLIGHT, "more items in flight than registers")

endmodule

bind gated_short_causal_conv3 gscc_checker u_gscc_checker (.*);

// ===== bench/gated_short_causal_conv3_tb.sv =====
// ----------------------------------------------------------------------------
// gated_short_causal_conv3_tb
// Self-checking bench for the gated three-tap causal convolution. A short
// table of hand-picked items (range extremes, rounding ties, history shifts)
// runs first. Random items follow, mostly aimed at a few hot layer-channel
// pairs so that histories fill and back-to-back bypass paths are hit. Every
// result is checked against a table value or a Q3.12 model kept in the bench.
// ----------------------------------------------------------------------------
module gated_short_causal_conv3_tb
    import gscc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1934;
    localparam int DIR_ROWS     = 16;
    localparam int HOT_PAIRS    = 6;
    localparam int MODE_SPAN    = 40;
    localparam int MAX_WAIT     = 14;

    typedef struct {
        logic [LAYER_W-1:0] layer;
        logic [CHAN_W-1:0]  chan;
        q_t                 b;
        q_t                 c;
        q_t                 x;
        q_t                 w0;
        q_t                 w1;
        q_t                 w2;
    } conv_item_t;

    typedef struct packed {
        q_t   value;
        logic clipped;
    } conv_out_t;

    // Table row: fields as plain integers, then an optional hand-computed result.
    typedef struct {
        int layer;
        int chan;
        int b;
        int c;
        int x;
        int w0;
        int w1;
        int w2;
        bit typed;
        int exp_value;
        bit exp_clipped;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    logic [31:0] conv_history [int];
    conv_out_t   pending_results [$];
    int          error_count = 0;
    int          items_sent = 0;
    int          results_checked = 0;
    int          clipped_seen = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int unsigned hot_layer [HOT_PAIRS];
    int unsigned hot_chan [HOT_PAIRS];

    dir_row_t dir_table [DIR_ROWS] = '{
        // Fresh history everywhere after reset: zero in gives zero out.
        '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0},
        // Unity gains at the top layer and channel.
        '{15, 2047, 4096, 4096, 4096, 0, 0, 4096, 1'b1, 4096, 1'b0},
        // Range extremes: every stage clips.
        '{15, 0, -32768, -32768, -32768, -32768, -32768, 32767, 1'b1, -32768, 1'b1},
        '{15, 1, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 32767, 1'b1},
        '{0, 1, -32768, 32767, 32767, 0, 0, -32768, 1'b1, 32767, 1'b1},
        // Rounding ties and near-ties on the gated sample.
        '{0, 2, 1, 4096, 2048, 0, 0, 4096, 1'b0, 0, 1'b0},
        '{0, 3, -1, 4096, 2048, 0, 0, 4096, 1'b0, 0, 1'b0},
        '{0, 4, 1, 4096, 2047, 0, 0, 4096, 1'b0, 0, 1'b0},
        '{0, 5, -1, 4096, 2049, 0, 0, 4096, 1'b0, 0, 1'b0},
        // A run on one pair: the history shifts through both taps.
        '{7, 100, 4096, 4096, 1000, 1024, 2048, 4096, 1'b0, 0, 1'b0},
        '{7, 100, 4096, 4096, -3000, 1024, 2048, 4096, 1'b0, 0, 1'b0},
        '{7, 100, 4096, 4096, 5000, 1024, 2048, 4096, 1'b0, 0, 1'b0},
        '{7, 100, 8192, -4096, 700, -2048, 3000, -1000, 1'b0, 0, 1'b0},
        // Tiny output gate: the last stage rounds small values away.
        '{7, 100, 4096, 1, 2047, 4096, 4096, 4096, 1'b0, 0, 1'b0},
        // The convolution sum overflows; the second row clips every stage.
        '{8, 1365, 4096, 2048, 16384, 0, 0, 32767, 1'b0, 0, 1'b0},
        '{8, 682, 20000, -20000, 20000, 0, 0, 20000, 1'b0, 0, 1'b0}
    };

    gated_short_causal_conv3 DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(input conv_item_t it);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[OFS_LAYER +: LAYER_W] = it.layer;
        d[OFS_CHAN +: CHAN_W]   = it.chan;
        d[OFS_B +: Q_W]         = it.b;
        d[OFS_C +: Q_W]         = it.c;
        d[OFS_X +: Q_W]         = it.x;
        d[OFS_W0 +: Q_W]        = it.w0;
        d[OFS_W1 +: Q_W]        = it.w1;
        d[OFS_W2 +: Q_W]        = it.w2;
        return d;
    endfunction

    // Q6.24 down to Q3.12, rounding half up, then clipping to 16 bits.
    function automatic q_t q312_round(input longint full, inout bit clipped);
        longint r;
        r = (full + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > Q_MAX)
        begin
            clipped = 1'b1;
            return q_t'(Q_MAX);
        end
        if (r < Q_MIN)
        begin
            clipped = 1'b1;
            return q_t'(Q_MIN);
        end
        return q_t'(r);
    endfunction

    // Works out the result of one item and shifts its gated sample into history.
    function automatic conv_out_t predict_conv(input conv_item_t it);
        conv_out_t   res;
        bit          clipped;
        bit          in_range;
        int          key;
        logic [31:0] entry;
        q_t          h_old;
        q_t          h_new;
        q_t          g;
        q_t          y;
        longint      sum;
        clipped  = 1'b0;
        in_range = (it.layer < LAYERS) && (it.chan < CHANNELS);
        key      = int'(it.layer) * CHANNELS + int'(it.chan);
        entry    = (in_range && conv_history.exists(key)) ? conv_history[key] : 32'd0;
        h_old    = q_t'(entry[15:0]);
        h_new    = q_t'(entry[31:16]);
        g        = q312_round(longint'(it.b) * longint'(it.x), clipped);
        sum      = longint'(it.w0) * longint'(h_old) + longint'(it.w1) * longint'(h_new)
                 + longint'(it.w2) * longint'(g);
        y        = q312_round(sum, clipped);
        if (in_range)
            conv_history[key] = {g, h_new};
        res.value   = q312_round(longint'(y) * longint'(it.c), clipped);
        res.clipped = clipped;
        return res;
    endfunction

    function automatic q_t rand_q();
        int unsigned pick;
        int unsigned corner;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return q_t'($urandom_range(0, 65535));
        if (pick < 3)
        begin
            corner = $urandom_range(0, 5);
            case (corner)
                0: return q_t'(Q_MIN);
                1: return q_t'(Q_MIN + 1);
                2: return q_t'(-1);
                3: return q_t'(0);
                4: return q_t'(1);
                default: return q_t'(Q_MAX);
            endcase
        end
        // Moderate magnitudes keep most results out of saturation.
        return q_t'(int'($urandom_range(0, 16383)) - 8192);
    endfunction

    function automatic conv_item_t rand_item();
        conv_item_t  it;
        int unsigned slot;
        if ($urandom_range(0, 9) < 7)
        begin
            slot     = $urandom_range(0, HOT_PAIRS - 1);
            it.layer = LAYER_W'(hot_layer[slot]);
            it.chan  = CHAN_W'(hot_chan[slot]);
        end
        else
        begin
            it.layer = LAYER_W'($urandom_range(0, (1 << LAYER_W) - 1));
            it.chan  = CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1));
        end
        it.b  = rand_q();
        it.c  = rand_q();
        it.x  = rand_q();
        it.w0 = rand_q();
        it.w1 = rand_q();
        it.w2 = rand_q();
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic drive_item(input conv_item_t it, input bit typed, input conv_out_t typed_res);
        int        gap;
        conv_out_t pred;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= pack_item(it);
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = predict_conv(it);
        pending_results.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    // Holds the input quiet until every outstanding result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(posedge clk)
    begin
        conv_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %h/%b with no item outstanding",
                                          m_axis_tdata, m_axis_tuser));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch($sformatf("result %0d: conv_result %h, expected %h",
                                              results_checked, m_axis_tdata, want.value));
                if (m_axis_tuser !== want.clipped)
                    report_mismatch($sformatf("result %0d: saturated %b, expected %b",
                                              results_checked, m_axis_tuser, want.clipped));
                results_checked++;
                if (want.clipped)
                    clipped_seen++;
            end
        end
    end

    // Result side: a random stall before each item, with stretches of none.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        forever
        begin
            if (taken % MODE_SPAN == 0)
                recv_burst = ($urandom_range(0, 3) == 0);
            stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        conv_item_t it;
        conv_out_t  typed_res;
        for (int i = 0; i < HOT_PAIRS; i++)
        begin
            hot_layer[i] = $urandom_range(0, (1 << LAYER_W) - 1);
            hot_chan[i]  = $urandom_range(0, (1 << CHAN_W) - 1);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i])
        begin
            it.layer            = LAYER_W'(dir_table[i].layer);
            it.chan             = CHAN_W'(dir_table[i].chan);
            it.b                = q_t'(dir_table[i].b);
            it.c                = q_t'(dir_table[i].c);
            it.x                = q_t'(dir_table[i].x);
            it.w0               = q_t'(dir_table[i].w0);
            it.w1               = q_t'(dir_table[i].w1);
            it.w2               = q_t'(dir_table[i].w2);
            typed_res.value     = q_t'(dir_table[i].exp_value);
            typed_res.clipped   = dir_table[i].exp_clipped;
            drive_item(it, dir_table[i].typed, typed_res);
        end
        drain_results();

        typed_res = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % MODE_SPAN == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            drive_item(rand_item(), 1'b0, typed_res);
        end
        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d items (%0d from the table), checked %0d results, %0d saturated.",
                 items_sent, DIR_ROWS, results_checked, clipped_seen);
        $display("Mismatches: %0d.", error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("gated_short_causal_conv3_tb passed");
        else
            $display("gated_short_causal_conv3_tb failed");
        $finish;
    end

    // Covers the history clear after reset plus the slowest handshake pattern.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("gated_short_causal_conv3_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/gscc_pkg.sv
design/gscc_hist_ram.sv
design/gscc_gate_stage.sv
design/gscc_conv_pipe.sv
design/gated_short_causal_conv3.sv
design/gscc_checker.sv
bench/gated_short_causal_conv3_tb.sv
